>>> hdl/rct_pkg.sv
package rct_pkg;

    // Field widths
    localparam int ACT_W  = 3;
    localparam int IDX_W  = 2;
    localparam int VAL_W  = 16;
    localparam int PRE_W  = 24;
    localparam int MODE_W = 10;
    localparam int IRQ_W  = 7;
    localparam int MUL_W  = 25;

    typedef logic [ACT_W-1:0]  action_t;
    typedef logic [IDX_W-1:0]  index_t;
    typedef logic [VAL_W-1:0]  value_t;
    typedef logic [PRE_W-1:0]  presc_t;
    typedef logic [MODE_W-1:0] mode_t;
    typedef logic [IRQ_W-1:0]  irq_t;

    // Bus access codes
    localparam action_t ACT_TICK     = 3'd0;
    localparam action_t ACT_WR_COUNT = 3'd1;
    localparam action_t ACT_WR_MODE  = 3'd2;
    localparam action_t ACT_WR_TGT   = 3'd3;
    localparam action_t ACT_RD_COUNT = 3'd4;

    // Mode bits
    localparam mode_t MODE_GATE      = 10'h001;
    localparam mode_t MODE_IRQ_TGT   = 10'h010;
    localparam mode_t MODE_IRQ_ANY   = 10'h030;
    localparam mode_t MODE_REPEAT    = 10'h040;
    localparam mode_t MODE_SRC_MASK  = 10'h300;
    localparam mode_t MODE_SRC_DOT   = 10'h100;
    localparam mode_t MODE_SRC_SYS8  = 10'h200;
    localparam mode_t VSYNC_MODE_RST = 10'h058;

    localparam value_t COUNT_MAX     = 16'hffff;
    localparam value_t VSYNC_TGT_RST = 16'h0001;
    localparam presc_t SYS8_RATE     = 24'd8;
    localparam presc_t RATE_ONE      = 24'd1;

    localparam int IRQ_VSYNC_BIT = 0;
    localparam int IRQ_GEN_BASE  = 4;
    localparam int GATED_IDX     = 2;

    localparam int RESET_PERIOD = 564480;

    localparam int NUM_COUNTERS_DEF    = 4;
    localparam int LINES_PER_FRAME_DEF = 262;
    localparam int DOTS_PER_LINE_DEF   = 386;

    // Interrupt armed when an interrupt source is selected, except a gated counter 2
    function automatic logic arm_condition(input logic gated_idx, input mode_t mode);
        logic gated;
        gated = gated_idx && ((mode & MODE_GATE) != '0);
        return !gated && ((mode & MODE_IRQ_ANY) != '0);
    endfunction

endpackage

>>> hdl/rct_ifs.sv
interface rct_cmd_if;
    logic             valid;
    logic             ready;
    rct_pkg::action_t action;
    rct_pkg::index_t  counter_index;
    rct_pkg::value_t  write_value;

    modport source (output valid, output action, output counter_index, output write_value,
                    input ready);
    modport sink   (input valid, input action, input counter_index, input write_value,
                    output ready);
endinterface

interface rct_result_if;
    logic            valid;
    logic            ready;
    rct_pkg::value_t read_count;
    rct_pkg::irq_t   irq_set;

    modport source (output valid, output read_count, output irq_set, input ready);
    modport sink   (input valid, input read_count, input irq_set, output ready);
endinterface

>>> hdl/root_counter_timer_bank_core.sv
// The input register loads on the accepting edge and moves to the result register once that
// register is empty or taken. Throughput: 1 transaction per cycle unless a result is held;
// every counter updates in parallel on a tick.
// The line and frame rates are derived from vsync_period by constant reciprocal multiplies,
// registered together with the period, so they follow a configuration write at once.
// Reset (rst_n, asynchronous, active low): counters, prescalers and targets clear, vsync
// counter mode 0x58 target 1 and armed, vsync_period 564480; no clearing pass.
module root_counter_timer_bank_core #(
    parameter int NUM_COUNTERS    = rct_pkg::NUM_COUNTERS_DEF,
    parameter int LINES_PER_FRAME = rct_pkg::LINES_PER_FRAME_DEF,
    parameter int DOTS_PER_LINE   = rct_pkg::DOTS_PER_LINE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  rct_pkg::presc_t      cfg_wr_data,
    rct_cmd_if.sink              cmd,
    rct_result_if.source         result
);

    // The last counter is the vertical-sync counter
    localparam int VSYNC_IDX = NUM_COUNTERS - 1;
    localparam int NUM_GEN   = NUM_COUNTERS - 1;
    localparam int FRAME_DIV = DOTS_PER_LINE * LINES_PER_FRAME;

    // Exact floor division of a 24-bit value by a constant: multiply by the rounded-up
    // reciprocal scaled by 2^(24 + ceil(log2 d)), then shift back down
    localparam int PROD_W   = rct_pkg::PRE_W + rct_pkg::MUL_W;
    localparam int LINE_SH  = rct_pkg::PRE_W + $clog2(LINES_PER_FRAME);
    localparam int FRAME_SH = rct_pkg::PRE_W + $clog2(FRAME_DIV);
    localparam longint unsigned LINE_MUL =
        ((64'd1 << LINE_SH) + 64'(LINES_PER_FRAME) - 64'd1) / 64'(LINES_PER_FRAME);
    localparam longint unsigned FRAME_MUL =
        ((64'd1 << FRAME_SH) + 64'(FRAME_DIV) - 64'd1) / 64'(FRAME_DIV);

    localparam int RST_LINE_Q  = rct_pkg::RESET_PERIOD / LINES_PER_FRAME;
    localparam int RST_FRAME_Q = rct_pkg::RESET_PERIOD / FRAME_DIV;
    localparam int RST_LINE    = (RST_LINE_Q == 0) ? 1 : RST_LINE_Q;
    localparam int RST_FRAME   = (RST_FRAME_Q == 0) ? 1 : RST_FRAME_Q;

    // Configuration and derived rates
    rct_pkg::presc_t period_reg;
    rct_pkg::presc_t period_next;
    rct_pkg::presc_t rate_base;
    rct_pkg::presc_t line_rate_reg;
    rct_pkg::presc_t frame_rate_reg;
    rct_pkg::presc_t vsync_rate;
    logic [PROD_W-1:0] line_prod;
    logic [PROD_W-1:0] frame_prod;
    rct_pkg::presc_t line_quo;
    rct_pkg::presc_t frame_quo;
    rct_pkg::presc_t line_rate_next;
    rct_pkg::presc_t frame_rate_next;

    // Input register
    logic             in_valid_reg;
    rct_pkg::action_t in_act_reg;
    rct_pkg::index_t  in_idx_reg;
    rct_pkg::value_t  in_val_reg;

    // Result register
    logic            out_valid_reg;
    rct_pkg::value_t out_read_reg;
    rct_pkg::irq_t   out_irq_reg;
    rct_pkg::value_t read_next;
    rct_pkg::irq_t   irq_next;

    // Counter state
    rct_pkg::value_t value_reg    [NUM_COUNTERS];
    rct_pkg::value_t value_next   [NUM_COUNTERS];
    rct_pkg::presc_t presc_reg    [NUM_COUNTERS];
    rct_pkg::presc_t presc_next   [NUM_COUNTERS];
    rct_pkg::mode_t  mode_reg     [NUM_COUNTERS];
    rct_pkg::mode_t  mode_next    [NUM_COUNTERS];
    rct_pkg::value_t target_reg   [NUM_COUNTERS];
    rct_pkg::value_t target_next  [NUM_COUNTERS];
    rct_pkg::presc_t rate_reg     [NUM_GEN];
    rct_pkg::presc_t rate_next    [NUM_GEN];
    logic [NUM_COUNTERS-1:0] armed_reg;
    logic [NUM_COUNTERS-1:0] armed_next;

    logic advance;
    logic proc_fire;

    // The result register moves when empty or taken; the input register refills behind it
    assign advance      = !out_valid_reg || result.ready;
    assign proc_fire    = in_valid_reg && advance;
    assign cmd.ready    = !in_valid_reg || advance;

    assign result.valid      = out_valid_reg;
    assign result.read_count = out_read_reg;
    assign result.irq_set    = out_irq_reg;

    // A zero period runs as one tick per step
    assign vsync_rate = (period_reg == '0) ? rct_pkg::RATE_ONE : period_reg;

    // Derive the line and frame rates from the period being loaded, so they land with it
    assign period_next = cfg_wr_en ? cfg_wr_data : period_reg;
    assign rate_base   = (period_next == '0) ? rct_pkg::RATE_ONE : period_next;

    assign line_prod  = PROD_W'(rate_base) * PROD_W'(LINE_MUL);
    assign frame_prod = PROD_W'(rate_base) * PROD_W'(FRAME_MUL);
    assign line_quo   = rct_pkg::presc_t'(line_prod >> LINE_SH);
    assign frame_quo  = rct_pkg::presc_t'(frame_prod >> FRAME_SH);
    assign line_rate_next  = (line_quo == '0) ? rct_pkg::RATE_ONE : line_quo;
    assign frame_rate_next = (frame_quo == '0) ? rct_pkg::RATE_ONE : frame_quo;

    // Work out one transaction against the counter state
    always_comb
    begin
        logic            idx_ok;
        logic            sel;
        logic            hit;
        rct_pkg::presc_t eff_rate;
        rct_pkg::presc_t pre_inc;
        rct_pkg::value_t val_inc;
        rct_pkg::mode_t  new_mode;
        rct_pkg::mode_t  src;

        value_next  = value_reg;
        presc_next  = presc_reg;
        mode_next   = mode_reg;
        target_next = target_reg;
        rate_next   = rate_reg;
        armed_next  = armed_reg;
        read_next   = '0;
        irq_next    = '0;
        sel         = 1'b0;
        hit         = 1'b0;
        eff_rate    = rct_pkg::RATE_ONE;
        pre_inc     = '0;
        val_inc     = '0;
        new_mode    = in_val_reg[rct_pkg::MODE_W-1:0];
        src         = new_mode & rct_pkg::MODE_SRC_MASK;
        idx_ok      = 4'(in_idx_reg) < 4'(NUM_COUNTERS);

        if (proc_fire)
        begin
            unique case (in_act_reg)
                rct_pkg::ACT_TICK:
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        eff_rate = (i == VSYNC_IDX) ? vsync_rate : rate_reg[i % NUM_GEN];
                        pre_inc  = presc_reg[i] + rct_pkg::RATE_ONE;
                        val_inc  = value_reg[i] + rct_pkg::value_t'(1);
                        if (pre_inc < eff_rate)
                        begin
                            presc_next[i] = pre_inc;
                        end
                        else
                        begin
                            presc_next[i] = '0;
                            value_next[i] = val_inc;
                            if ((mode_reg[i] & rct_pkg::MODE_IRQ_TGT) != '0)
                                hit = (val_inc == target_reg[i]);
                            else
                                hit = (val_inc == rct_pkg::COUNT_MAX);
                            if (armed_reg[i] && hit)
                            begin
                                value_next[i] = '0;
                                if (i == VSYNC_IDX)
                                    irq_next[rct_pkg::IRQ_VSYNC_BIT] = 1'b1;
                                else if (rct_pkg::IRQ_GEN_BASE + i < rct_pkg::IRQ_W)
                                    irq_next = irq_next
                                        | (rct_pkg::irq_t'(1) << (rct_pkg::IRQ_GEN_BASE + i));
                                // Drop the arm unless repeating; vsync always repeats
                                if (i != VSYNC_IDX
                                    && (mode_reg[i] & rct_pkg::MODE_REPEAT) == '0)
                                    armed_next[i] = 1'b0;
                            end
                        end
                    end
                end
                rct_pkg::ACT_WR_COUNT:
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        sel = idx_ok && (4'(in_idx_reg) == 4'(i));
                        if (sel)
                        begin
                            value_next[i] = in_val_reg;
                            presc_next[i] = '0;
                            armed_next[i] = rct_pkg::arm_condition(i == rct_pkg::GATED_IDX,
                                                                   mode_reg[i]);
                        end
                    end
                end
                rct_pkg::ACT_WR_MODE:
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        sel = idx_ok && (4'(in_idx_reg) == 4'(i));
                        if (sel)
                        begin
                            mode_next[i]  = new_mode;
                            value_next[i] = '0;
                            presc_next[i] = '0;
                            armed_next[i] = rct_pkg::arm_condition(i == rct_pkg::GATED_IDX,
                                                                   new_mode);
                            // Pick the clock source; the vsync counter keeps its rate
                            if (i != VSYNC_IDX)
                            begin
                                if (i == 0 && src == rct_pkg::MODE_SRC_DOT)
                                    rate_next[i % NUM_GEN] = frame_rate_reg;
                                else if (i == 1 && src == rct_pkg::MODE_SRC_DOT)
                                    rate_next[i % NUM_GEN] = line_rate_reg;
                                else if (i == 2 && src == rct_pkg::MODE_SRC_SYS8)
                                    rate_next[i % NUM_GEN] = rct_pkg::SYS8_RATE;
                                else
                                    rate_next[i % NUM_GEN] = rct_pkg::RATE_ONE;
                            end
                        end
                    end
                end
                rct_pkg::ACT_WR_TGT:
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        sel = idx_ok && (4'(in_idx_reg) == 4'(i));
                        if (sel)
                        begin
                            target_next[i] = in_val_reg;
                            presc_next[i]  = '0;
                            armed_next[i]  = rct_pkg::arm_condition(i == rct_pkg::GATED_IDX,
                                                                    mode_reg[i]);
                        end
                    end
                end
                rct_pkg::ACT_RD_COUNT:
                begin
                    for (int i = 0; i < NUM_COUNTERS; i++)
                    begin
                        sel = idx_ok && (4'(in_idx_reg) == 4'(i));
                        if (sel)
                            read_next = value_reg[i];
                    end
                end
                default:
                begin
                    // Unused codes change nothing and return zeros
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= rct_pkg::presc_t'(rct_pkg::RESET_PERIOD);
            line_rate_reg  <= rct_pkg::presc_t'(RST_LINE);
            frame_rate_reg <= rct_pkg::presc_t'(RST_FRAME);
            in_valid_reg   <= 1'b0;
            in_act_reg     <= rct_pkg::ACT_TICK;
            in_idx_reg     <= '0;
            in_val_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_read_reg   <= '0;
            out_irq_reg    <= '0;
            for (int i = 0; i < NUM_COUNTERS; i++)
            begin
                value_reg[i]  <= '0;
                presc_reg[i]  <= '0;
                mode_reg[i]   <= (i == VSYNC_IDX) ? rct_pkg::VSYNC_MODE_RST : '0;
                target_reg[i] <= (i == VSYNC_IDX) ? rct_pkg::VSYNC_TGT_RST : '0;
                armed_reg[i]  <= (i == VSYNC_IDX);
            end
            for (int i = 0; i < NUM_GEN; i++)
                rate_reg[i] <= rct_pkg::RATE_ONE;
        end
        else
        begin
            period_reg     <= period_next;
            line_rate_reg  <= line_rate_next;
            frame_rate_reg <= frame_rate_next;

            // Hold the transaction until the result register can take its result
            if (cmd.valid && cmd.ready)
            begin
                in_valid_reg <= 1'b1;
                in_act_reg   <= cmd.action;
                in_idx_reg   <= cmd.counter_index;
                in_val_reg   <= cmd.write_value;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
                out_read_reg  <= read_next;
                out_irq_reg   <= irq_next;
            end

            value_reg  <= value_next;
            presc_reg  <= presc_next;
            mode_reg   <= mode_next;
            target_reg <= target_next;
            rate_reg   <= rate_next;
            armed_reg  <= armed_next;
        end
    end

`ifndef SYNTHESIS
    // Only a tick raises interrupt bits
    a_irq_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_act_reg != rct_pkg::ACT_TICK |-> irq_next == '0)
        else $error("interrupt raised by a bus access");

    // A mode write to counter 0 leaves its count at zero
    a_mode_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && in_act_reg == rct_pkg::ACT_WR_MODE && in_idx_reg == '0
        |=> value_reg[0] == '0)
        else $error("mode write did not clear the count");

    // A stalled transaction stays in the input register
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_act_reg)
                                     && $stable(in_idx_reg) && $stable(in_val_reg))
        else $error("stalled transaction lost");

    // Derived rates never fall to zero
    a_rates_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_rate_reg != '0 && frame_rate_reg != '0)
        else $error("derived rate is zero");
`endif

endmodule
